// File: rtl/phd_pkg.sv
// Shared types and constants for the peak and hold dot driver.
`default_nettype none

package phd_pkg;

  localparam int unsigned TIMER_BITS_DEF = 24;
  localparam int unsigned ADC_BITS_DEF   = 12;

  localparam int unsigned CUR_W  = 13;
  localparam int unsigned LEN_W  = 24;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 24;

  // mA per count is 1250 / 1024
  localparam int unsigned SCALE_MUL   = 1250;
  localparam int unsigned SCALE_SHIFT = 10;

  localparam logic [CUR_W-1:0] START_RST  = CUR_W'(800);
  localparam logic [CUR_W-1:0] HOLD_RST   = CUR_W'(400);
  localparam logic [CUR_W-1:0] BAND_RST   = CUR_W'(30);
  localparam logic [LEN_W-1:0] LENGTH_RST = LEN_W'(2000);
  localparam logic [LEN_W-1:0] PERIOD_RST = LEN_W'(20000);

  typedef enum logic [CFG_AW-1:0] {
    REG_START  = 3'd0,
    REG_HOLD   = 3'd1,
    REG_BAND   = 3'd2,
    REG_LENGTH = 3'd3,
    REG_PERIOD = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_DOT  = 2'd1,
    OP_RUN  = 2'd2,
    OP_STOP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RAMP = 2'd1,
    PH_HOLD = 2'd2
  } phase_e;

  typedef struct packed {
    logic [CUR_W-1:0] start_current;
    logic [CUR_W-1:0] hold_current;
    logic [CUR_W-1:0] hold_band;
    logic [LEN_W-1:0] dot_length;
    logic [LEN_W-1:0] repeat_period;
  } cfg_t;

  typedef struct packed {
    logic   drive_on;
    phase_e phase;
    logic   running;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/phd_cfg_regs.sv
// Configuration register file of the peak and hold dot driver.
`default_nettype none

module phd_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [phd_pkg::CFG_AW-1:0] cfg_addr_i,
  input  wire logic [phd_pkg::CFG_DW-1:0] cfg_data_i,
  output phd_pkg::cfg_t                   cfg_o
);

  phd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        phd_pkg::REG_START:  cfg_d.start_current = cfg_data_i[phd_pkg::CUR_W-1:0];
        phd_pkg::REG_HOLD:   cfg_d.hold_current  = cfg_data_i[phd_pkg::CUR_W-1:0];
        phd_pkg::REG_BAND:   cfg_d.hold_band     = cfg_data_i[phd_pkg::CUR_W-1:0];
        phd_pkg::REG_LENGTH: cfg_d.dot_length    = cfg_data_i[phd_pkg::LEN_W-1:0];
        phd_pkg::REG_PERIOD: cfg_d.repeat_period = cfg_data_i[phd_pkg::LEN_W-1:0];
        default: ; // unknown index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_current <= phd_pkg::START_RST;
      cfg_q.hold_current  <= phd_pkg::HOLD_RST;
      cfg_q.hold_band     <= phd_pkg::BAND_RST;
      cfg_q.dot_length    <= phd_pkg::LENGTH_RST;
      cfg_q.repeat_period <= phd_pkg::PERIOD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/phd_ctrl.sv
// Dot state machine, timers and current comparisons, one update per tick.
`default_nettype none

module phd_ctrl #(
  parameter int unsigned TIMER_BITS = phd_pkg::TIMER_BITS_DEF,
  parameter int unsigned ADC_BITS   = phd_pkg::ADC_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [1:0]          op_i,
  input  wire logic [ADC_BITS-1:0] adc_i,
  input  wire phd_pkg::cfg_t       cfg_i,
  output phd_pkg::result_t         res_o
);

  localparam int unsigned PROD_W = ADC_BITS + 11;
  localparam int unsigned MA_W   = PROD_W - phd_pkg::SCALE_SHIFT;
  localparam int unsigned CW     =
    ((MA_W > phd_pkg::CUR_W) ? MA_W : phd_pkg::CUR_W) + 1;
  localparam int unsigned PW     =
    (TIMER_BITS > phd_pkg::LEN_W) ? TIMER_BITS : phd_pkg::LEN_W;
  localparam logic [TIMER_BITS-1:0] TMAX   = {TIMER_BITS{1'b1}};
  localparam logic [PW-1:0]         TMAX_W = PW'(TMAX);

  phd_pkg::phase_e         phase_q, phase_d;
  logic                    run_q, run_d;
  logic                    drive_q, drive_d;
  logic [TIMER_BITS-1:0]   elapsed_q, elapsed_d;
  logic [TIMER_BITS-1:0]   count_q, count_d;

  logic [PROD_W-1:0] prod;
  logic [MA_W-1:0]   ma;
  logic [CW-1:0]     ma_x, start_x, hold_x, band_x;
  logic [PW-1:0]     period_x;
  logic [TIMER_BITS-1:0] period_ld;

  assign prod     = PROD_W'(adc_i) * PROD_W'(phd_pkg::SCALE_MUL);
  assign ma       = prod[PROD_W-1:phd_pkg::SCALE_SHIFT];
  assign ma_x     = CW'(ma);
  assign start_x  = CW'(cfg_i.start_current);
  assign hold_x   = CW'(cfg_i.hold_current);
  assign band_x   = CW'(cfg_i.hold_band);
  assign period_x = PW'(cfg_i.repeat_period);
  assign period_ld = (period_x > TMAX_W) ? TMAX : TIMER_BITS'(period_x);

  // next state
  always_comb begin
    phase_d   = phase_q;
    run_d     = run_q;
    drive_d   = drive_q;
    elapsed_d = elapsed_q;
    count_d   = count_q;

    case (op_i)
      phd_pkg::OP_DOT: begin
        run_d = 1'b0;
        if (phase_q == phd_pkg::PH_IDLE) begin
          phase_d   = phd_pkg::PH_RAMP;
          elapsed_d = '0;
        end
      end
      phd_pkg::OP_RUN: begin
        run_d   = 1'b1;
        count_d = '0;
      end
      phd_pkg::OP_STOP: begin
        run_d   = 1'b0;
        phase_d = phd_pkg::PH_IDLE;
        drive_d = 1'b0;
      end
      default: ;
    endcase

    if (count_d != '0) count_d = count_d - 1'b1;
    if (run_d && phase_d == phd_pkg::PH_IDLE && count_d == '0) begin
      phase_d   = phd_pkg::PH_RAMP;
      elapsed_d = '0;
      count_d   = period_ld;
    end

    if (phase_d == phd_pkg::PH_IDLE) begin
      drive_d = 1'b0;
    end else if (PW'(elapsed_d) > PW'(cfg_i.dot_length)) begin
      phase_d = phd_pkg::PH_IDLE;
      drive_d = 1'b0;
    end else begin
      if (phase_d == phd_pkg::PH_RAMP) begin
        drive_d = 1'b1;
        if (ma_x >= start_x) phase_d = phd_pkg::PH_HOLD;
      end else begin
        // hysteresis; low side written as ma + band < hold to stay unsigned
        if (ma_x > hold_x + band_x) drive_d = 1'b0;
        else if (ma_x + band_x < hold_x) drive_d = 1'b1;
      end
      if (elapsed_d != TMAX) elapsed_d = elapsed_d + 1'b1;
    end
  end

  // result of this tick
  always_comb begin
    res_o.drive_on = drive_d;
    res_o.phase    = phase_d;
    res_o.running  = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= phd_pkg::PH_IDLE;
      run_q     <= 1'b0;
      drive_q   <= 1'b0;
      elapsed_q <= '0;
      count_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      run_q     <= run_d;
      drive_q   <= drive_d;
      elapsed_q <= elapsed_d;
      count_q   <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/peak_hold_dot_driver_top.sv
// Top level of the peak and hold dot driver.
//
// Usage: one input request per microsecond tick carries a command
// (operation_i: tick only, single dot, run, stop) and the current-sense
// sample adc_sample_i. Each request yields exactly one result request with
// the driver state (drive_on_o), the dot phase (phase_o) and the run flag
// (running_o) as they stand after that tick's update.
// Both channels are valid/ready. The configuration port (cfg_we_i,
// cfg_addr_i, cfg_data_i) writes one register per cycle, no wait; write
// it only while no request is in flight.
// An accepted request waits in the input register, then its update lands
// in the result register. Throughput: one request per cycle while the
// result is not stalled; the whole update is a single pass of compares, a
// constant multiply and two counters between the input and result registers.
// Stall: a result waiting on out_ready_i holds; the input register still
// takes one more request, then in_ready_o drops until the result drains.
// Reset: both valids clear, the dot state goes idle with the driver off,
// run mode off, timers zero, registers back to their defaults.
`default_nettype none

module peak_hold_dot_driver_top #(
  parameter int unsigned TIMER_BITS = phd_pkg::TIMER_BITS_DEF,
  parameter int unsigned ADC_BITS   = phd_pkg::ADC_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [phd_pkg::CFG_AW-1:0] cfg_addr_i,
  input  wire logic [phd_pkg::CFG_DW-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 operation_i,
  input  wire logic [ADC_BITS-1:0]        adc_sample_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            drive_on_o,
  output logic [1:0]                      phase_o,
  output logic                            running_o
);

  phd_pkg::cfg_t    cfg;
  phd_pkg::result_t res;

  // input register
  logic                in_vld_q;
  logic [1:0]          op_q;
  logic [ADC_BITS-1:0] adc_q;
  // result register
  logic                out_vld_q;
  phd_pkg::result_t    res_q;

  logic adv; // input register moves into the result register

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  phd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  phd_ctrl #(
    .TIMER_BITS (TIMER_BITS),
    .ADC_BITS   (ADC_BITS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .op_i   (op_q),
    .adc_i  (adc_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (adv) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= operation_i;
      adc_q <= adc_sample_i;
    end
    if (adv) res_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign drive_on_o  = res_q.drive_on;
  assign phase_o     = res_q.phase;
  assign running_o   = res_q.running;

endmodule

`default_nettype wire

// File: rtl/phd_checker.sv
// Port-level checks for the peak and hold dot driver, bound to the top.
`default_nettype none

module phd_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic                       drive_on_o,
  input wire logic [1:0]                 phase_o,
  input wire logic                       running_o
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(drive_on_o) && $stable(phase_o) && $stable(running_o))
    else $error("result changed while stalled");

  // idle means driver off
  a_idle_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_o == phd_pkg::PH_IDLE |-> !drive_on_o)
    else $error("driver on while idle");

  // ramp always drives fully on
  a_ramp_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_o == phd_pkg::PH_RAMP |-> drive_on_o)
    else $error("driver off during ramp");

  // with a full pipe and a stalled result, no new request is taken
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && in_valid_i && in_ready_o |=>
      !out_ready_i |-> !in_ready_o)
    else $error("input accepted past a full pipe");

endmodule

bind peak_hold_dot_driver_top phd_checker u_phd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .drive_on_o   (drive_on_o),
  .phase_o      (phase_o),
  .running_o    (running_o)
);

`default_nettype wire
